@@ rtl/lbs_pkg.sv @@
// Shared types and constants for the LED blink sequencer with RGB frame output.
// Depends on nothing; every other file in rtl/ imports it.
package lbs_pkg;

  // Default parameter values for the top level.
  localparam int unsigned FrameBitsDef = 24;
  localparam int unsigned TimeWidthDef = 16;

  // Width of the stored colour word: red, green, blue bytes.
  localparam int unsigned ColourBits = 24;

  // Width of the configuration data bus.
  localparam int unsigned CfgDataW = 8;

  // Symbol timing in 100 ns units.
  localparam logic [3:0] SymOneHigh  = 4'd8;
  localparam logic [3:0] SymOneLow   = 4'd4;
  localparam logic [3:0] SymZeroHigh = 4'd4;
  localparam logic [3:0] SymZeroLow  = 4'd8;

  // Command codes. The fourth code is ignored.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SET   = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_RGB_MODE = 1'b0,
    REG_PIN_INV  = 1'b1
  } cfg_reg_e;

  // One input beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  blink_count;
    logic [15:0] time_on;
    logic [15:0] time_off;
    logic [7:0]  red_byte;
    logic [7:0]  green_byte;
    logic [7:0]  blue_byte;
    logic        level;
    logic        take_colour;
  } lbs_in_t;

  // One output beat.
  typedef struct packed {
    logic       pin_level;
    logic [3:0] high_time;
    logic [3:0] low_time;
    logic       last_symbol;
  } lbs_out_t;

  // Frame request from the sequencer to the symbol transmitter.
  typedef struct packed {
    logic valid;
    logic plain;
    logic pin;
  } lbs_req_t;

  // Builds one RGB symbol beat.
  function automatic lbs_out_t make_sym(input logic bit_val, input logic last);
    lbs_out_t s;
    s.pin_level   = 1'b0;
    s.high_time   = bit_val ? SymOneHigh : SymZeroHigh;
    s.low_time    = bit_val ? SymOneLow : SymZeroLow;
    s.last_symbol = last;
    return s;
  endfunction

endpackage

@@ rtl/lbs_seq.sv @@
// Blink sequencer: input register, run state and the per-item state update.
// Depends on lbs_pkg; hands frame requests to lbs_tx.
module lbs_seq import lbs_pkg::*; #(
  parameter int unsigned FRAME_BITS = FrameBitsDef,
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lbs_in_t               in_data_i,
  input  logic                  rgb_mode_i,
  input  logic                  pin_inv_i,
  input  logic                  load_ok_i,
  output lbs_req_t              req_o,
  output logic [FRAME_BITS-1:0] frame_o
);

  lbs_in_t                item_q;
  logic                   item_valid_q, item_valid_d;
  logic                   in_take, proc, drive;

  logic                   running_q, running_d;
  logic                   lit_q, lit_d;
  logic [7:0]             blinks_q, blinks_d, blinks_dec;
  logic [TIME_WIDTH-1:0]  on_q, on_d, off_q, off_d;
  logic [TIME_WIDTH-1:0]  elapsed_q, elapsed_d, elapsed_inc, dur;
  logic [ColourBits-1:0]  colour_q, colour_d, colour_in;

  // Input register: holds one beat until the state update can complete.
  assign in_stall_o   = item_valid_q && !proc;
  assign in_take      = in_valid_i && !in_stall_o;
  assign item_valid_d = in_take ? 1'b1 : (proc ? 1'b0 : item_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // Saturating elapsed count and the duration of the current phase.
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + TIME_WIDTH'(1) : elapsed_q;
  assign dur         = lit_q ? on_q : off_q;
  assign blinks_dec  = lit_q ? blinks_q - 8'd1 : blinks_q;
  assign colour_in   = {item_q.red_byte, item_q.green_byte, item_q.blue_byte};

  // State update for the beat held in the input register.
  always_comb begin
    running_d = running_q;
    lit_d     = lit_q;
    blinks_d  = blinks_q;
    on_d      = on_q;
    off_d     = off_q;
    elapsed_d = elapsed_q;
    colour_d  = colour_q;
    drive     = 1'b0;
    case (item_q.command)
      CMD_START: begin
        blinks_d  = item_q.blink_count;
        on_d      = TIME_WIDTH'(item_q.time_on);
        off_d     = TIME_WIDTH'(item_q.time_off);
        colour_d  = colour_in;
        running_d = 1'b1;
        lit_d     = 1'b0;
        elapsed_d = '0;
      end
      CMD_SET: begin
        if (item_q.take_colour) begin
          colour_d = colour_in;
        end
        lit_d = item_q.level;
        drive = 1'b1;
      end
      CMD_TICK: begin
        if (running_q) begin
          if (elapsed_inc < dur) begin
            elapsed_d = elapsed_inc;
          end else begin
            // Phase over: toggle, count the blink on the falling edge.
            blinks_d  = blinks_dec;
            lit_d     = !lit_q;
            drive     = 1'b1;
            elapsed_d = '0;
            if (blinks_dec == 8'd0) begin
              running_d = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A beat completes unless it drives the LED while the transmitter is busy.
  assign proc = item_valid_q && (!drive || load_ok_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      lit_q     <= 1'b0;
      blinks_q  <= '0;
      on_q      <= '0;
      off_q     <= '0;
      elapsed_q <= '0;
      colour_q  <= '0;
    end else if (proc) begin
      running_q <= running_d;
      lit_q     <= lit_d;
      blinks_q  <= blinks_d;
      on_q      <= on_d;
      off_q     <= off_d;
      elapsed_q <= elapsed_d;
      colour_q  <= colour_d;
    end
  end

  // Frame contents: colour bits when lit, zeros above the colour word.
  for (genvar p = 0; p < FRAME_BITS; p++) begin : g_frame
    if (p < ColourBits) begin : g_col
      assign frame_o[p] = lit_d & colour_d[p];
    end else begin : g_pad
      assign frame_o[p] = 1'b0;
    end
  end

  assign req_o.valid = proc && drive;
  assign req_o.plain = !rgb_mode_i;
  assign req_o.pin   = lit_d ^ pin_inv_i;

endmodule

@@ rtl/lbs_tx.sv @@
// Symbol transmitter: turns a frame request into output beats.
// Depends on lbs_pkg; fed by lbs_seq.
module lbs_tx import lbs_pkg::*; #(
  parameter int unsigned FRAME_BITS = FrameBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lbs_req_t              req_i,
  input  logic [FRAME_BITS-1:0] frame_i,
  output logic                  load_ok_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lbs_out_t              out_data_o
);

  localparam int unsigned CntW = $clog2(FRAME_BITS);

  lbs_out_t              out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0] sh_q, sh_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  out_take;

  // A new frame may load once the last beat of the current one leaves.
  assign out_take  = out_valid_q && !out_stall_i;
  assign load_ok_o = !out_valid_q || (out_take && cnt_q == '0);

  // Load a new frame, or step to the next symbol when a beat is taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    if (req_i.valid) begin
      out_valid_d = 1'b1;
      if (req_i.plain) begin
        out_d.pin_level   = req_i.pin;
        out_d.high_time   = 4'd0;
        out_d.low_time    = 4'd0;
        out_d.last_symbol = 1'b1;
        cnt_d             = '0;
      end else begin
        out_d = make_sym(frame_i[FRAME_BITS-1], 1'b0);
        sh_d  = frame_i << 1;
        cnt_d = CntW'(FRAME_BITS - 1);
      end
    end else if (out_take) begin
      if (cnt_q != '0) begin
        out_d = make_sym(sh_q[FRAME_BITS-1], cnt_q == CntW'(1));
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CntW'(1);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sh_q  <= sh_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/led_blink_sequencer_rgb_frame.sv @@
// Top level of the status LED blink sequencer with RGB symbol frame output.
// Depends on lbs_pkg, lbs_seq and lbs_tx.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i): one beat per command,
//   a one millisecond tick, a start blink or a set level.
// - Output channel (out_valid_o / out_stall_i / out_data_o): one beat per
//   symbol. In RGB mode an LED change gives FRAME_BITS beats, MSB first; in
//   plain mode it gives one pin level beat. The final beat has last_symbol.
// - Configuration (cfg_valid_i / cfg_ready_o): index 0 is rgb_mode, index 1
//   is pin_inverted, taken from bit 0 of cfg_data_i. Always ready.
// Timing: a beat is registered in the input register on accept; its state
// update then completes in the same cycle as the first symbol is loaded into
// the output register. Commands that do not drive the LED go at
// one per cycle. A command that drives the LED waits in the input register
// until the previous frame's last beat leaves, so the rate there is set by
// the symbol shifter: FRAME_BITS beats (or one in plain mode) per change,
// plus any output stall.
// Reset clears the run state and the colour, selects RGB mode and no pin
// inversion, and empties both registers. While the receiver stalls, the
// current beat holds and the input stalls once a second change is pending.
module led_blink_sequencer_rgb_frame import lbs_pkg::*; #(
  parameter int unsigned FRAME_BITS = FrameBitsDef,
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbs_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic                  rgb_mode_q, pin_inv_q;
  logic                  load_ok;
  lbs_req_t              req;
  logic [FRAME_BITS-1:0] frame;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_mode_q <= 1'b1;
      pin_inv_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RGB_MODE: rgb_mode_q <= cfg_data_i[0];
        REG_PIN_INV:  pin_inv_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and per-beat update.
  lbs_seq #(
    .FRAME_BITS(FRAME_BITS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .rgb_mode_i(rgb_mode_q),
    .pin_inv_i (pin_inv_q),
    .load_ok_i (load_ok),
    .req_o     (req),
    .frame_o   (frame)
  );

  // Symbol shifter and output register.
  lbs_tx #(
    .FRAME_BITS(FRAME_BITS)
  ) u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .frame_i    (frame),
    .load_ok_o  (load_ok),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // A frame is only handed over when the transmitter can take it.
  a_req_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |-> load_ok)
    else $error("frame request while transmitter busy");

  // RGB symbols carry one of the two legal timing pairs.
  a_sym_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.high_time != 4'd0) |->
      ((out_data_o.high_time == SymOneHigh && out_data_o.low_time == SymOneLow) ||
       (out_data_o.high_time == SymZeroHigh && out_data_o.low_time == SymZeroLow)))
    else $error("bad symbol timing");

  // A plain beat with the pin level high is always a single, final beat with no timing.
  a_plain_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pin_level) |->
      (out_data_o.high_time == 4'd0 && out_data_o.last_symbol))
    else $error("plain pin beat malformed");

endmodule
